// ===== design/hsg_pkg.sv =====
// ----------------------------------------------------------------------------
// hsg_pkg: shared types and constants for the HOTP generator
// SHA-1 constants, sequencer states and helpers.
// ----------------------------------------------------------------------------
package hsg_pkg;

    localparam int KEY_WORDS   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CODE_W      = 27;
    localparam int RECIP_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS = 3'd5;

    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5C5C5C5C;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [31:0] MOD6 = 32'd1000000;
    localparam logic [31:0] MOD7 = 32'd10000000;
    localparam logic [31:0] MOD8 = 32'd100000000;

    // floor(2^32 / modulus); quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP6 = 13'd4294;
    localparam logic [RECIP_W-1:0] RECIP7 = 13'd429;
    localparam logic [RECIP_W-1:0] RECIP8 = 13'd42;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IN_KEY,
        ST_IN_MSG,
        ST_OUT_KEY,
        ST_OUT_MSG,
        ST_TRUNC,
        ST_MOD,
        ST_DONE
    } t_state;

    // control from the sequencer to the compression core
    typedef struct packed {
        logic start;     // load block, begin 80 rounds
        logic init_iv;   // chain from IV rather than previous digest
    } t_core_ctl;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

endpackage

// ===== design/hsg_sha1_core.sv =====
// ----------------------------------------------------------------------------
// hsg_sha1_core: iterative SHA-1 compression
// One round per cycle over a 16-word schedule window.
// ----------------------------------------------------------------------------
module hsg_sha1_core
    import hsg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_core_ctl    i_ctl,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [159:0] o_digest
);

    logic [31:0]  r_w [16];
    logic [31:0]  n_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h;
    logic [6:0]   r_round;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  f, k, t;

    always_comb begin
        if (r_round < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = 32'h5A827999;
        end else if (r_round < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = 32'h6ED9EBA1;
        end else if (r_round < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = 32'h8F1BBCDC;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = 32'hCA62C1D6;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];
        for (int i = 0; i < 15; i++) begin
            n_w[i] = r_w[i+1];
        end
        n_w[15] = rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                if (r_round == 7'd79) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_round <= r_round + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511-32*i -: 32];
            end
            if (i_ctl.init_iv) begin
                r_h <= SHA1_IV;
                {r_a, r_b, r_c, r_d, r_e} <= SHA1_IV;
            end else begin
                {r_a, r_b, r_c, r_d, r_e} <= r_h;
            end
        end else if (r_busy) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= n_w[i];
            end
            r_a <= t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
            if (r_round == 7'd79) begin
                r_h <= {r_h[159:128] + t, r_h[127:96] + r_a,
                        r_h[95:64] + {r_b[1:0], r_b[31:2]},
                        r_h[63:32] + r_c, r_h[31:0] + r_d};
            end
        end
    end

    assign o_done   = r_done;
    assign o_digest = r_h;

endmodule

// ===== design/hsg_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hsg_mod_unit: remainder by reciprocal multiplication
// Quotient estimate, back-multiply, subtract, one correction.
// ----------------------------------------------------------------------------
module hsg_mod_unit
    import hsg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_value,
    input  logic [31:0]        i_modulus,
    input  logic [RECIP_W-1:0] i_recip,
    output logic               o_done,
    output logic [CODE_W-1:0]  o_rem
);

    logic [31:0]          r_val;
    logic [31:0]          r_mod;
    logic [RECIP_W-1:0]   r_recip;
    logic [31+RECIP_W:0]  r_prod;
    logic [31:0]          r_qd;
    logic [31:0]          r_rem;
    logic [1:0]           r_step;
    logic                 r_busy;
    logic                 r_done;
    logic [31+RECIP_W:0]  qd_full;

    assign qd_full = {32'd0, r_prod[31+RECIP_W:32]} * {{RECIP_W{1'b0}}, r_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val   <= i_value;
            r_mod   <= i_modulus;
            r_recip <= i_recip;
        end else if (r_busy) begin
            unique case (r_step)
                2'd0: r_prod <= {{RECIP_W{1'b0}}, r_val} * {32'd0, r_recip};
                2'd1: r_qd   <= qd_full[31:0];
                2'd2: r_rem  <= r_val - r_qd;
                2'd3: begin
                    // estimate may be one short
                    if (r_rem >= r_mod) begin
                        r_rem <= r_rem - r_mod;
                    end
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[CODE_W-1:0];

endmodule

// ===== design/hotp_sha1_generator_unit.sv =====
// ----------------------------------------------------------------------------
// hotp_sha1_generator_unit: HOTP code generator (HMAC-SHA1, RFC 4226 style)
//
// Write key words 0-4 and the digit count (index 5) on the config channel
// while the block is idle. Each request on the input channel carries a
// 64-bit moving counter; one request on the output channel returns the
// numeric code modulo 10^6, 10^7 or 10^8.
// Each request runs four SHA-1 compressions on the one-round-per-cycle
// core (launch, block load, 80 rounds each), a truncation step and the
// reciprocal remainder. One request at a time; o_ready is low from accept
// until the result is taken.
// Reset clears the key to zero and the digit count to six. If the receiver
// stalls, the result holds on o_otp_code until o_valid and i_out_ready meet.
// ----------------------------------------------------------------------------
module hotp_sha1_generator_unit
    import hsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [63:0]          i_moving_counter,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    output logic [CODE_W-1:0]    o_otp_code
);

    t_state       r_state, n_state;
    logic [31:0]  r_key [KEY_WORDS];
    logic [3:0]   r_digits;
    logic [63:0]  r_ctr;
    logic [159:0] r_inner;
    logic [31:0]  r_trunc;
    logic [CODE_W-1:0] r_code;
    logic         r_launch;
    t_core_ctl    core_ctl;
    logic [511:0] blk;
    logic         core_done;
    logic [159:0] digest;
    logic         mod_start, mod_done;
    logic [CODE_W-1:0] mod_rem;
    logic [31:0]  modulus;
    logic [RECIP_W-1:0] recip;
    logic [3:0]   off;
    logic [159:0] dsh;
    logic         in_acc, out_acc;

    assign o_cfg_ready = 1'b1;
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
            r_digits <= 4'd6;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DIGITS) begin
                r_digits <= i_cfg_data[3:0];
            end else if (i_cfg_index < CFG_DIGITS) begin
                r_key[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_acc) n_state = ST_IN_KEY;
            ST_IN_KEY:  if (core_done) n_state = ST_IN_MSG;
            ST_IN_MSG:  if (core_done) n_state = ST_OUT_KEY;
            ST_OUT_KEY: if (core_done) n_state = ST_OUT_MSG;
            ST_OUT_MSG: if (core_done) n_state = ST_TRUNC;
            ST_TRUNC:   n_state = ST_MOD;
            ST_MOD:     if (mod_done) n_state = ST_DONE;
            ST_DONE:    if (out_acc) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_DONE: o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            // start the core as each block phase begins
            r_launch <= (n_state != r_state) &&
                        (n_state == ST_IN_KEY || n_state == ST_IN_MSG ||
                         n_state == ST_OUT_KEY || n_state == ST_OUT_MSG);
        end
    end

    always_comb begin
        blk = '0;
        unique case (r_state)
            ST_IN_KEY, ST_OUT_KEY: begin
                for (int i = 0; i < 16; i++) begin
                    blk[511-32*i -: 32] = (r_state == ST_IN_KEY) ? IPAD : OPAD;
                end
                for (int i = 0; i < KEY_WORDS; i++) begin
                    blk[511-32*i -: 32] = r_key[i] ^
                        ((r_state == ST_IN_KEY) ? IPAD : OPAD);
                end
            end
            ST_IN_MSG:
                blk = {r_ctr, 32'h80000000, 384'd0, 32'd576};
            ST_OUT_MSG:
                blk = {r_inner, 32'h80000000, 288'd0, 32'd672};
            default: blk = '0;
        endcase
        core_ctl.start   = r_launch;
        core_ctl.init_iv = (r_state == ST_IN_KEY) || (r_state == ST_OUT_KEY);
    end

    hsg_sha1_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_block  (blk),
        .o_done   (core_done),
        .o_digest (digest)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ctr <= i_moving_counter;
        end
        if (r_state == ST_IN_MSG && core_done) begin
            r_inner <= digest;
        end
        if (r_state == ST_OUT_MSG && core_done) begin
            r_trunc <= {1'b0, dsh[158:128]};
        end
        if (mod_done) begin
            r_code <= mod_rem;
        end
    end

    assign off = digest[3:0];
    assign dsh = digest << {off, 3'b000};

    always_comb begin
        priority if (r_digits <= 4'd6) begin
            modulus = MOD6;
            recip   = RECIP6;
        end else if (r_digits == 4'd7) begin
            modulus = MOD7;
            recip   = RECIP7;
        end else begin
            modulus = MOD8;
            recip   = RECIP8;
        end
    end

    assign mod_start = (r_state == ST_TRUNC);

    hsg_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_value   (r_trunc),
        .i_modulus (modulus),
        .i_recip   (recip),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    assign o_otp_code = r_code;

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_otp_code < 27'd100000000))
        else $error("code out of range");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("accepted while busy");

    a_core_only_hashing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (r_state == ST_IN_KEY || r_state == ST_IN_MSG ||
                       r_state == ST_OUT_KEY || r_state == ST_OUT_MSG))
        else $error("core done outside hash phase");

    a_trunc_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |-> !r_trunc[31])
        else $error("truncated value top bit set");

endmodule
